### hdl/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hdl/pclst_pkg.sv
`timescale 1ns / 1ps
package pclst_pkg;
    localparam int CPUS        = 8;
    localparam int STACK_DEPTH = 128;
    localparam int LOCKS       = 4096;

    localparam int CPU_W  = (CPUS > 1) ? $clog2(CPUS) : 1;
    localparam int SLOT_W = $clog2(STACK_DEPTH);
    localparam int DEP_W  = $clog2(STACK_DEPTH + 1);
    localparam int LOCK_W = $clog2(LOCKS);
    localparam int STK_W  = CPU_W + SLOT_W;
    localparam int HOLD_W = 11;

    localparam logic [2:0] CMD_WAIT    = 3'd0;
    localparam logic [2:0] CMD_ACQUIRE = 3'd1;
    localparam logic [2:0] CMD_RELEASE = 3'd2;
    localparam logic [2:0] CMD_PROBE   = 3'd3;
    localparam logic [2:0] CMD_QUERY   = 3'd4;
    localparam logic [2:0] CMD_RESET   = 3'd5;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_IGNORED   = 4'd1;
    localparam logic [3:0] ST_UNINIT    = 4'd2;
    localparam logic [3:0] ST_REENTRANT = 4'd3;
    localparam logic [3:0] ST_NOT_WAIT  = 4'd4;
    localparam logic [3:0] ST_TOP_MISS  = 4'd5;
    localparam logic [3:0] ST_ORDER     = 4'd6;
    localparam logic [3:0] ST_DOUBLE    = 4'd7;
    localparam logic [3:0] ST_FOREIGN   = 4'd8;
    localparam logic [3:0] ST_NOT_FOUND = 4'd9;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LREAD,
        S_TREAD,
        S_SCAN,
        S_SCAN_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_RELEASE,
        S_ACQ_WR,
        S_CLEAR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic               we;
        logic [STK_W-1:0]   waddr;
        logic [LOCK_W-1:0]  wlock;
        logic               wowned;
        logic               wr_wait;
        logic [63:0]        wwait;
        logic               wr_own;
        logic [63:0]        wown;
        logic [STK_W-1:0]   raddr;
    } stk_ctl_t;

    typedef struct packed {
        logic               we;
        logic [LOCK_W-1:0]  waddr;
        logic               wr_tot;
        logic [63:0]        wtot_wait;
        logic [63:0]        wtot_own;
        logic               wr_meta;
        logic [HOLD_W-1:0]  whold;
        logic [2:0]         wcpu;
        logic [31:0]        wsite;
        logic [LOCK_W-1:0]  raddr;
    } lck_ctl_t;
endpackage

### hdl/pclst_stack_mem.sv
`timescale 1ns / 1ps
module pclst_stack_mem
    import pclst_pkg::*;
(
    input  logic              clk,
    input  stk_ctl_t          ctl,
    output logic [LOCK_W-1:0] rlock,
    output logic              rowned,
    output logic [63:0]       rwait,
    output logic [63:0]       rown
);
    localparam int N = CPUS * STACK_DEPTH;

    logic [LOCK_W:0] meta_mem [N];
    logic [63:0]     wait_mem [N];
    logic [63:0]     own_mem  [N];

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            meta_mem[ctl.waddr] <= {ctl.wowned, ctl.wlock};
        end
        if (ctl.we && ctl.wr_wait)
        begin
            wait_mem[ctl.waddr] <= ctl.wwait;
        end
        if (ctl.we && ctl.wr_own)
        begin
            own_mem[ctl.waddr] <= ctl.wown;
        end
        {rowned, rlock} <= meta_mem[ctl.raddr];
        rwait <= wait_mem[ctl.raddr];
        rown  <= own_mem[ctl.raddr];
    end
endmodule

### hdl/pclst_lock_mem.sv
`timescale 1ns / 1ps
module pclst_lock_mem
    import pclst_pkg::*;
(
    input  logic              clk,
    input  lck_ctl_t          ctl,
    output logic [63:0]       rtot_wait,
    output logic [63:0]       rtot_own,
    output logic [HOLD_W-1:0] rhold,
    output logic [2:0]        rcpu,
    output logic [31:0]       rsite
);
    logic [127:0]           tot_mem  [LOCKS];
    logic [HOLD_W+34:0]     meta_mem [LOCKS];

    always_ff @(posedge clk)
    begin
        if (ctl.we && ctl.wr_tot)
        begin
            tot_mem[ctl.waddr] <= {ctl.wtot_own, ctl.wtot_wait};
        end
        if (ctl.we && ctl.wr_meta)
        begin
            meta_mem[ctl.waddr] <= {ctl.whold, ctl.wcpu, ctl.wsite};
        end
        {rtot_own, rtot_wait} <= tot_mem[ctl.raddr];
        {rhold, rcpu, rsite}  <= meta_mem[ctl.raddr];
    end
endmodule

### hdl/per_cpu_lock_stack_tracker.sv
// Per-CPU lock stack tracker. One item at a time; in_stall is high while an item
// is worked. Wait and probe walk the CPU's stack one entry at a time, reading
// and then checking each entry; release scans likewise and then shifts newer
// entries down, reading and then writing each one. The per-lock tables sit in
// memories with no reset, so after reset and after a reset-all command a
// clearing pass over all LOCKS (4096) entries runs before the next item is
// taken. A result waits in an output register; the next item is taken once it
// has been delivered.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module per_cpu_lock_stack_tracker
    import pclst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic [7:0]  cpu_id,
    input  logic [15:0] lock_index,
    input  logic        lock_initialized,
    input  logic        silent_reentrance,
    input  logic        silent_not_on_top,
    input  logic [31:0] call_site,
    input  logic [63:0] timestamp,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  status,
    output logic        would_hang,
    output logic [63:0] total_wait,
    output logic [63:0] total_own,
    output logic [2:0]  last_owner_cpu,
    output logic [31:0] last_owner_site
);
    state_t state_reg, state_next;
    logic   en_reg;
    logic   boot_reg;
    logic [DEP_W-1:0] depth_reg [CPUS];

    logic [2:0]        cmd_reg;
    logic [CPU_W-1:0]  cpu_reg;
    logic [LOCK_W-1:0] lk_reg;
    logic              sil_re_reg, sil_top_reg;
    logic [31:0]       site_reg;
    logic [63:0]       ts_reg;
    logic [DEP_W-1:0]  d_reg, d_next;
    logic [DEP_W-1:0]  i_reg, i_next;
    logic              hit_reg, hit_next;
    logic [LOCK_W-1:0] clr_reg, clr_next;

    logic [3:0]  st_reg, st_next;
    logic        hang_reg, hang_next;
    logic [63:0] ow_reg, oo_reg;
    logic [2:0]  oc_reg;
    logic [31:0] os_reg;
    logic        ov_reg;
    logic        done;

    stk_ctl_t sc;
    lck_ctl_t lc;
    logic [LOCK_W-1:0] s_lock;
    logic              s_owned;
    logic [63:0]       s_wait, s_own;
    logic [63:0]       l_tw, l_to;
    logic [HOLD_W-1:0] l_hold;
    logic [2:0]        l_cpu;
    logic [31:0]       l_site;

    logic [STK_W-1:0]  base;
    logic              cpu_ok, lk_ok;
    logic [DEP_W-1:0]  d_in;
    logic [LOCK_W-1:0] sv_lock;
    logic [63:0]       sv_wait, sv_own;
    logic              sv_owned;

    pclst_stack_mem u_stk (
        .clk    (clk),
        .ctl    (sc),
        .rlock  (s_lock),
        .rowned (s_owned),
        .rwait  (s_wait),
        .rown   (s_own)
    );

    pclst_lock_mem u_lck (
        .clk       (clk),
        .ctl       (lc),
        .rtot_wait (l_tw),
        .rtot_own  (l_to),
        .rhold     (l_hold),
        .rcpu      (l_cpu),
        .rsite     (l_site)
    );

    assign in_stall = (state_reg != S_IDLE) || ov_reg;
    assign out_valid = ov_reg;
    assign status = st_reg;
    assign would_hang = hang_reg;
    assign total_wait = ow_reg;
    assign total_own = oo_reg;
    assign last_owner_cpu = oc_reg;
    assign last_owner_site = os_reg;

    assign cpu_ok = ({8'd0, cpu_id} < 16'(CPUS));
    assign lk_ok  = ({16'd0, lock_index} < 32'(LOCKS));
    assign base   = {cpu_reg, {SLOT_W{1'b0}}};
    assign d_in   = depth_reg[cpu_id[CPU_W-1:0]];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    if (cmd == CMD_QUERY)
                        state_next = lk_ok ? S_LREAD : S_DONE;
                    else if (cmd == CMD_RESET)
                        state_next = S_CLEAR;
                    else if (cmd > CMD_RESET || !en_reg || !cpu_ok || !lk_ok)
                        state_next = S_DONE;
                    else if (((cmd == CMD_WAIT || cmd == CMD_PROBE)
                              && d_in >= DEP_W'(STACK_DEPTH))
                             || (cmd == CMD_RELEASE && d_in == '0))
                        state_next = S_DONE;
                    else if (lock_index == '0 || !lock_initialized)
                        state_next = S_DONE;
                    else if (cmd == CMD_ACQUIRE)
                        state_next = (d_in == '0) ? S_DONE : S_TREAD;
                    else
                        state_next = S_SCAN;
                end
            end
            S_LREAD:    state_next = S_DONE;
            S_TREAD:    state_next = S_ACQ_WR;
            S_ACQ_WR:   state_next = S_DONE;
            S_SCAN:
            begin
                if (i_reg == '0)
                    state_next = (cmd_reg == CMD_RELEASE) ? S_RELEASE : S_DONE;
                else
                    state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (s_lock == lk_reg && (cmd_reg == CMD_RELEASE))
                    state_next = S_RELEASE;
                else if (s_lock == lk_reg && cmd_reg == CMD_PROBE)
                    state_next = S_DONE;
                else
                    state_next = S_SCAN;
            end
            S_RELEASE:  state_next = hit_reg ? S_SHIFT_RD : S_DONE;
            S_SHIFT_RD: state_next = (i_reg + 1'b1 >= d_reg) ? S_DONE : S_SHIFT_WR;
            S_SHIFT_WR: state_next = S_SHIFT_RD;
            S_CLEAR:    state_next = (clr_reg == LOCK_W'(LOCKS - 1)) ? S_DONE : S_CLEAR;
            S_DONE:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    assign sv_lock  = s_lock;
    assign sv_wait  = s_wait;
    assign sv_own   = s_own;
    assign sv_owned = s_owned;

    always_comb
    begin
        sc = '0;
        lc = '0;
        d_next = d_reg;
        i_next = i_reg;
        hit_next = hit_reg;
        clr_next = clr_reg;
        st_next = st_reg;
        hang_next = hang_reg;
        done = 1'b0;
        lc.raddr = lk_reg;
        sc.raddr = base + STK_W'(i_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                lc.raddr = lock_index[LOCK_W-1:0];
                sc.raddr = {cpu_id[CPU_W-1:0], {SLOT_W{1'b0}}}
                           + STK_W'(d_in - 1'b1);
                if (in_valid && !in_stall)
                begin
                    st_next = ST_IGNORED;
                    hang_next = 1'b0;
                    hit_next = 1'b0;
                    clr_next = '0;
                    d_next = d_in;
                    i_next = d_in;
                    if (cmd == CMD_QUERY)
                        st_next = lk_ok ? ST_OK : ST_NOT_FOUND;
                    else if (cmd == CMD_RESET)
                        st_next = ST_OK;
                    else if (cmd <= CMD_RESET && en_reg && cpu_ok && lk_ok
                             && !(((cmd == CMD_WAIT || cmd == CMD_PROBE)
                                   && d_in >= DEP_W'(STACK_DEPTH))
                                  || (cmd == CMD_RELEASE && d_in == '0)))
                    begin
                        if (lock_index == '0 || !lock_initialized)
                            st_next = ST_UNINIT;
                        else if (cmd == CMD_ACQUIRE && d_in == '0)
                            st_next = ST_NOT_WAIT;
                        else
                            st_next = ST_OK;
                    end
                end
            end
            S_TREAD:
            begin
                sc.raddr = base + STK_W'(d_reg - 1'b1);
            end
            S_ACQ_WR:
            begin
                if (sv_owned)
                    st_next = ST_NOT_WAIT;
                else if (sv_lock != lk_reg)
                    st_next = ST_TOP_MISS;
                else
                begin
                    sc.we = 1'b1;
                    sc.waddr = base + STK_W'(d_reg - 1'b1);
                    sc.wlock = lk_reg;
                    sc.wowned = 1'b1;
                    sc.wr_wait = 1'b1;
                    sc.wwait = sv_wait;
                    sc.wr_own = 1'b1;
                    sc.wown = ts_reg;
                    lc.we = 1'b1;
                    lc.waddr = lk_reg;
                    lc.wr_tot = 1'b1;
                    lc.wtot_wait = l_tw + (ts_reg - sv_wait);
                    lc.wtot_own = l_to;
                    lc.wr_meta = 1'b1;
                    lc.whold = l_hold + 1'b1;
                    lc.wcpu = 3'(cpu_reg);
                    lc.wsite = site_reg;
                end
            end
            S_SCAN:
            begin
                if (i_reg != '0)
                begin
                    i_next = i_reg - 1'b1;
                    sc.raddr = base + STK_W'(i_reg - 1'b1);
                end
                else if (cmd_reg == CMD_WAIT)
                begin
                    sc.we = 1'b1;
                    sc.waddr = base + STK_W'(d_reg);
                    sc.wlock = lk_reg;
                    sc.wowned = 1'b0;
                    sc.wr_wait = 1'b1;
                    sc.wwait = ts_reg;
                    if (hit_reg && !sil_re_reg)
                        st_next = ST_REENTRANT;
                end
            end
            S_SCAN_CHK:
            begin
                if (s_lock == lk_reg)
                begin
                    hit_next = 1'b1;
                    if (cmd_reg == CMD_PROBE)
                        hang_next = 1'b1;
                    else if (cmd_reg == CMD_RELEASE)
                        sc.raddr = base + STK_W'(i_reg);
                end
            end
            S_RELEASE:
            begin
                lc.we = 1'b1;
                lc.waddr = lk_reg;
                lc.wr_meta = 1'b1;
                lc.whold = (l_hold != '0) ? l_hold - 1'b1 : l_hold;
                lc.wcpu = l_cpu;
                lc.wsite = l_site;
                if (hit_reg)
                begin
                    lc.wr_tot = 1'b1;
                    lc.wtot_wait = l_tw;
                    lc.wtot_own = l_to + (ts_reg - sv_own);
                    st_next = (i_reg + 1'b1 != d_reg && !sil_top_reg) ? ST_ORDER : ST_OK;
                    sc.raddr = base + STK_W'(i_reg + 1'b1);
                end
                else
                    st_next = (l_hold != '0) ? ST_FOREIGN : ST_DOUBLE;
            end
            S_SHIFT_RD:
            begin
                if (i_reg + 1'b1 < d_reg)
                    sc.raddr = base + STK_W'(i_reg + 1'b1);
            end
            S_SHIFT_WR:
            begin
                sc.we = 1'b1;
                sc.waddr = base + STK_W'(i_reg);
                sc.wlock = s_lock;
                sc.wowned = s_owned;
                sc.wr_wait = 1'b1;
                sc.wwait = s_wait;
                sc.wr_own = 1'b1;
                sc.wown = s_own;
                i_next = i_reg + 1'b1;
                sc.raddr = base + STK_W'(i_reg + 2'd2);
            end
            S_CLEAR:
            begin
                lc.we = 1'b1;
                lc.waddr = clr_reg;
                lc.wr_tot = 1'b1;
                lc.wr_meta = boot_reg;
                clr_next = clr_reg + 1'b1;
            end
            S_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            en_reg <= 1'b1;
            boot_reg <= 1'b1;
            ov_reg <= 1'b0;
            clr_reg <= '0;
            for (int k = 0; k < CPUS; k++)
            begin
                depth_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            if (cfg_we)
                en_reg <= cfg_wdata;
            if (state_reg == S_DONE)
                boot_reg <= 1'b0;
            if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            if (done && !boot_reg)
                ov_reg <= 1'b1;
            if (state_reg == S_SCAN && i_reg == '0 && cmd_reg == CMD_WAIT)
                depth_reg[cpu_reg] <= d_reg + 1'b1;
            if (state_reg == S_RELEASE && hit_reg)
                depth_reg[cpu_reg] <= d_reg - 1'b1;
            if (state_reg == S_CLEAR && !boot_reg)
            begin
                en_reg <= 1'b1;
                for (int k = 0; k < CPUS; k++)
                begin
                    depth_reg[k] <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg <= d_next;
        i_reg <= i_next;
        hit_reg <= hit_next;
        st_reg <= st_next;
        hang_reg <= hang_next;
        if (state_reg == S_IDLE && in_valid && !in_stall)
        begin
            cmd_reg <= cmd;
            cpu_reg <= cpu_id[CPU_W-1:0];
            lk_reg <= lock_index[LOCK_W-1:0];
            sil_re_reg <= silent_reentrance;
            sil_top_reg <= silent_not_on_top;
            site_reg <= call_site;
            ts_reg <= timestamp;
            ow_reg <= '0;
            oo_reg <= '0;
            oc_reg <= '0;
            os_reg <= '0;
        end
        if (state_reg == S_LREAD)
        begin
            ow_reg <= l_tw;
            oo_reg <= l_to;
            oc_reg <= l_cpu;
            os_reg <= l_site;
        end
    end

    `ASSERT_IMPL(a_stall_busy, clk, rst_n, state_reg != S_IDLE, in_stall)
    `ASSERT_NEXT(a_done_out, clk, rst_n, state_reg == S_DONE && !boot_reg, out_valid)
    `ASSERT_IMPL(a_depth_cap, clk, rst_n, 1'b1, depth_reg[0] <= DEP_W'(STACK_DEPTH))
endmodule
